[design/dcts_pkg.sv]
// Package for the DMA channel transfer sequencer: request and result
// payload types, command and phase codes, address modes. No dependencies.
`default_nettype none

package dcts_pkg;

    typedef enum logic [1:0] {
        CMD_ENABLE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_EVENT  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        START_IMM     = 2'd0,
        START_VBLANK  = 2'd1,
        START_HBLANK  = 2'd2,
        START_SPECIAL = 2'd3
    } start_t;

    typedef enum logic [1:0] {
        MODE_INC    = 2'd0,
        MODE_DEC    = 2'd1,
        MODE_FIXED  = 2'd2,
        MODE_RELOAD = 2'd3
    } addr_mode_t;

    // Output phase codes
    localparam logic [2:0] PH_CODE_IDLE   = 3'd0;
    localparam logic [2:0] PH_CODE_WAIT   = 3'd1;
    localparam logic [2:0] PH_CODE_LOAD   = 3'd2;
    localparam logic [2:0] PH_CODE_RWAIT  = 3'd3;
    localparam logic [2:0] PH_CODE_REPEAT = 3'd4;
    localparam logic [2:0] PH_CODE_START  = 3'd5;
    localparam logic [2:0] PH_CODE_COPY   = 3'd6;
    localparam logic [2:0] PH_CODE_DONE   = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] REG_SOURCE  = 2'd0;
    localparam logic [1:0] REG_DEST    = 2'd1;
    localparam logic [1:0] REG_COUNT   = 2'd2;
    localparam logic [1:0] REG_CONTROL = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic       enable_value;
        logic [1:0] event_kind;
        logic       in_vblank;
        logic       in_hblank;
    } item_t;

    typedef struct packed {
        logic        beat_valid;
        logic [31:0] beat_source;
        logic [31:0] beat_dest;
        logic        beat_wide;
        logic        beat_sequential;
        logic        irq_pulse;
        logic        channel_active;
        logic [2:0]  phase;
    } result_t;

    // Latched transfer mode (control word bits 5-10, 12-14)
    typedef struct packed {
        logic       irq;
        start_t     start;
        logic       wide;
        logic       rpt;
        addr_mode_t src;
        addr_mode_t dst;
    } mode_t;

endpackage

`default_nettype wire

[design/dma_channel_transfer_sequencer_unit.sv]
// DMA channel transfer sequencer top level: one channel's phase machine,
// address and count registers, output register. Uses dcts_pkg.
`default_nettype none

// Usage:
//  - cfg_we/cfg_index/cfg_data write source, destination, count and control
//    registers; write only while no request is in flight.
//  - item_valid/item_stall carry one request per cycle while item_stall is low:
//    enable write, tick (one phase step) or start-condition event.
//  - result_valid/result_stall return exactly one result per request: beat
//    request with addresses, irq pulse, active flag and phase after the step.
//  - result_valid is registered after accept. Throughput is one request per
//    cycle unless stalled, set by the single state update and 32-bit address add.
//  - The result register holds while result_stall is high; a new request is
//    taken in the same cycle the held result leaves, so item_stall is high
//    only while a result is held and stalled.
//  - Reset clears all configuration and channel state; the channel comes up
//    idle and disabled with no result pending.
module dma_channel_transfer_sequencer_unit #(
    parameter int CHANNEL_ID = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [31:0]      cfg_data,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire dcts_pkg::item_t  item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output dcts_pkg::result_t     result
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_WAIT   = 8'b0000_0010,
        ST_LOAD   = 8'b0000_0100,
        ST_RWAIT  = 8'b0000_1000,
        ST_REPEAT = 8'b0001_0000,
        ST_START  = 8'b0010_0000,
        ST_COPY   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    localparam logic        FifoChan = (CHANNEL_ID == 1) || (CHANNEL_ID == 2);
    localparam logic [31:0] SrcMask  = (CHANNEL_ID == 0) ? 32'h07FF_FFFF : 32'h0FFF_FFFF;
    localparam logic [31:0] DstMask  = (CHANNEL_ID == 3) ? 32'h0FFF_FFFF : 32'h07FF_FFFF;
    localparam logic [15:0] CntMask  = (CHANNEL_ID == 3) ? 16'hFFFF : 16'h3FFF;
    localparam logic [16:0] CntMax   = (CHANNEL_ID == 3) ? 17'h1_0000 : 17'h0_4000;

    logic [31:0]     src_cfg_reg;
    logic [31:0]     dst_cfg_reg;
    logic [15:0]     cnt_cfg_reg;
    dcts_pkg::mode_t ctl_cfg_reg;

    state_t          state_reg,  state_next;
    logic            active_reg, active_next;
    logic [31:0]     cur_src_reg, cur_src_next;
    logic [31:0]     cur_dst_reg, cur_dst_next;
    logic [16:0]     remain_reg, remain_next;
    dcts_pkg::mode_t mode_reg,   mode_next;

    dcts_pkg::result_t result_reg, result_next;
    logic              result_valid_reg;
    logic              accept;

    function automatic logic [2:0] phase_code(input state_t s);
        logic [2:0] c;
        unique case (s)
            ST_IDLE:   c = dcts_pkg::PH_CODE_IDLE;
            ST_WAIT:   c = dcts_pkg::PH_CODE_WAIT;
            ST_LOAD:   c = dcts_pkg::PH_CODE_LOAD;
            ST_RWAIT:  c = dcts_pkg::PH_CODE_RWAIT;
            ST_REPEAT: c = dcts_pkg::PH_CODE_REPEAT;
            ST_START:  c = dcts_pkg::PH_CODE_START;
            ST_COPY:   c = dcts_pkg::PH_CODE_COPY;
            ST_DONE:   c = dcts_pkg::PH_CODE_DONE;
            default:   c = dcts_pkg::PH_CODE_IDLE;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] step_addr(input logic [31:0] a,
                                              input dcts_pkg::addr_mode_t m,
                                              input logic wide);
        logic [31:0] d;
        logic [31:0] r;
        d = wide ? 32'd4 : 32'd2;
        case (m)
            dcts_pkg::MODE_INC, dcts_pkg::MODE_RELOAD: r = a + d;
            dcts_pkg::MODE_DEC:                        r = a - d;
            default:                                   r = a;
        endcase
        return r;
    endfunction

    assign accept       = item_valid && !item_stall;
    assign item_stall   = result_valid_reg && result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_cfg_reg <= '0;
            dst_cfg_reg <= '0;
            cnt_cfg_reg <= '0;
            ctl_cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dcts_pkg::REG_SOURCE:  src_cfg_reg <= cfg_data;
                dcts_pkg::REG_DEST:    dst_cfg_reg <= cfg_data;
                dcts_pkg::REG_COUNT:   cnt_cfg_reg <= cfg_data[15:0];
                dcts_pkg::REG_CONTROL: ctl_cfg_reg <= {cfg_data[14:12], cfg_data[10:5]};
                default:               ;
            endcase
        end
    end

    // Phase machine and beat generation for one request
    always_comb
    begin
        logic           cnt_special;
        logic [16:0]    cnt_load;
        logic           ok;
        dcts_pkg::cmd_t cmd;

        state_next   = state_reg;
        active_next  = active_reg;
        cur_src_next = cur_src_reg;
        cur_dst_next = cur_dst_reg;
        remain_next  = remain_reg;
        mode_next    = mode_reg;
        result_next  = '0;
        ok           = 1'b0;
        cmd          = dcts_pkg::cmd_t'(item.cmd);

        // special start on the FIFO channels forces four words
        cnt_special = FifoChan && (mode_reg.start == dcts_pkg::START_SPECIAL);
        if (cnt_special)
            cnt_load = 17'd4;
        else if ((cnt_cfg_reg & CntMask) == 16'd0)
            cnt_load = CntMax;
        else
            cnt_load = {1'b0, cnt_cfg_reg & CntMask};

        case (cmd)
            dcts_pkg::CMD_ENABLE:
            begin
                active_next = item.enable_value;
                state_next  = ST_IDLE;
            end
            dcts_pkg::CMD_EVENT:
            begin
                if (item.event_kind == mode_reg.start)
                begin
                    if (state_reg == ST_WAIT)
                    begin
                        state_next  = ST_LOAD;
                        active_next = 1'b1;
                    end
                    else if (state_reg == ST_RWAIT)
                    begin
                        state_next  = ST_REPEAT;
                        active_next = 1'b1;
                    end
                end
            end
            dcts_pkg::CMD_TICK:
            begin
                if (active_reg)
                begin
                    unique case (state_reg)
                        ST_IDLE:
                        begin
                            mode_next = ctl_cfg_reg;
                            case (ctl_cfg_reg.start)
                                dcts_pkg::START_IMM:    ok = 1'b1;
                                dcts_pkg::START_VBLANK: ok = item.in_vblank;
                                dcts_pkg::START_HBLANK: ok = item.in_hblank && !item.in_vblank;
                                default:                ok = 1'b0;
                            endcase
                            if (ok)
                                state_next = ST_LOAD;
                            else
                            begin
                                state_next  = ST_WAIT;
                                active_next = 1'b0;
                            end
                        end
                        ST_LOAD:
                        begin
                            cur_src_next = src_cfg_reg & SrcMask;
                            cur_dst_next = dst_cfg_reg & DstMask;
                            if (cnt_special)
                            begin
                                mode_next.dst  = dcts_pkg::MODE_FIXED;
                                mode_next.src  = dcts_pkg::MODE_INC;
                                mode_next.wide = 1'b1;
                            end
                            remain_next = cnt_load;
                            state_next  = ST_START;
                        end
                        ST_REPEAT:
                        begin
                            if (mode_reg.dst == dcts_pkg::MODE_RELOAD)
                                cur_dst_next = dst_cfg_reg & DstMask;
                            remain_next = cnt_load;
                            state_next  = ST_START;
                        end
                        ST_START, ST_COPY:
                        begin
                            if (state_reg == ST_COPY && remain_reg == 17'd0)
                                state_next = ST_DONE;
                            else
                            begin
                                result_next.beat_valid      = 1'b1;
                                result_next.beat_source     = cur_src_reg;
                                result_next.beat_dest       = cur_dst_reg;
                                result_next.beat_wide       = mode_reg.wide;
                                result_next.beat_sequential = (state_reg == ST_COPY);
                                if (remain_reg != 17'd0)
                                    remain_next = remain_reg - 17'd1;
                                cur_src_next = step_addr(cur_src_reg, mode_reg.src,
                                                         mode_reg.wide);
                                cur_dst_next = step_addr(cur_dst_reg, mode_reg.dst,
                                                         mode_reg.wide);
                                state_next   = ST_COPY;
                            end
                        end
                        ST_DONE:
                        begin
                            if (mode_reg.rpt && mode_reg.start != dcts_pkg::START_IMM)
                                state_next = ST_RWAIT;
                            else
                            begin
                                state_next            = ST_IDLE;
                                active_next           = 1'b0;
                                result_next.irq_pulse = mode_reg.irq;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        result_next.channel_active = active_next;
        result_next.phase          = phase_code(state_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            active_reg       <= 1'b0;
            cur_src_reg      <= '0;
            cur_dst_reg      <= '0;
            remain_reg       <= '0;
            mode_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg        <= state_next;
                active_reg       <= active_next;
                cur_src_reg      <= cur_src_next;
                cur_dst_reg      <= cur_dst_next;
                remain_reg       <= remain_next;
                mode_reg         <= mode_next;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire
